### sv/k_smallest_row_sums_defines.svh
// Assertion macros for the k smallest row sums block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef K_SMALLEST_ROW_SUMS_DEFINES_SVH
`define K_SMALLEST_ROW_SUMS_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define KSRS_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSRS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define KSRS_ASSERT_SAME(lbl, pre, post, msg)
`define KSRS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### sv/ksrs_pkg.sv
package ksrs_pkg;

    localparam int MAX_K       = 16;
    localparam int VALUE_WIDTH = 20;
    localparam int SUM_WIDTH   = 24;
    localparam int LS_WIDTH    = 5;
    localparam int IDX_W       = $clog2(MAX_K);
    localparam int CNT_W       = $clog2(MAX_K + 1);

    localparam logic [LS_WIDTH-1:0]  LIST_SIZE_RESET = LS_WIDTH'(16);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX         = {SUM_WIDTH{1'b1}};

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IN,
        S_COPY,
        S_SCAN,
        S_WRITE,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    // Control from the sequencer to the row sorter.
    typedef struct packed {
        logic             ins;
        logic [CNT_W-1:0] count;
    } sort_ctrl_t;

endpackage

### sv/ksrs_ram.sv
module ksrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/ksrs_row_sorter.sv
module ksrs_row_sorter (
    input  logic                                clk,
    input  ksrs_pkg::sort_ctrl_t                ctrl,
    input  logic [ksrs_pkg::VALUE_WIDTH-1:0]    in_value,
    input  logic [ksrs_pkg::IDX_W-1:0]          rd_idx,
    output logic [ksrs_pkg::VALUE_WIDTH-1:0]    rd_data
);

    logic [ksrs_pkg::VALUE_WIDTH-1:0] row_reg [ksrs_pkg::MAX_K];
    logic [ksrs_pkg::VALUE_WIDTH-1:0] row_next [ksrs_pkg::MAX_K];
    logic [ksrs_pkg::MAX_K-1:0]       le;

    // Entries that stay in front of the new item form a prefix of the sorted row.
    always_comb
    begin
        for (int j = 0; j < ksrs_pkg::MAX_K; j++)
        begin
            le[j] = (ksrs_pkg::CNT_W'(j) < ctrl.count) && (row_reg[j] <= in_value);
        end
    end

    // Each slot keeps its entry, takes the new item, or takes its left neighbor.
    always_comb
    begin
        for (int j = 0; j < ksrs_pkg::MAX_K; j++)
        begin
            if (le[j])
            begin
                row_next[j] = row_reg[j];
            end
            else if (j == 0)
            begin
                row_next[j] = in_value;
            end
            else if (le[j-1])
            begin
                row_next[j] = in_value;
            end
            else
            begin
                row_next[j] = row_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            row_reg <= row_next;
        end
    end

    assign rd_data = row_reg[rd_idx];

endmodule

### sv/k_smallest_row_sums.sv
// Flow: after the last value of the last row, the row is merged into the list memory
// (copied in when k is 1), then the first sum is read and registered before out_valid.
// Input: one value per cycle while a row fills; each completed row holds off
// input while it is copied (row 0) or merged by scans of the list memory.
// Results: each sum is read from the list memory, registered, and held until out_ready.
// Reset: asynchronous, active low; list_size returns to 16 and all counters clear.
`include "k_smallest_row_sums_defines.svh"

module k_smallest_row_sums (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ksrs_pkg::LS_WIDTH-1:0]       cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ksrs_pkg::VALUE_WIDTH-1:0]    value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ksrs_pkg::SUM_WIDTH-1:0]      sum,
    output logic                                last
);

    localparam int AW = ksrs_pkg::IDX_W + 1;

    ksrs_pkg::state_t state_reg, state_next;

    logic [ksrs_pkg::LS_WIDTH-1:0]  list_size_reg;
    logic [ksrs_pkg::CNT_W-1:0]     k;
    logic [ksrs_pkg::CNT_W-1:0]     k_m1;
    logic [ksrs_pkg::CNT_W-1:0]     col_reg;
    logic [ksrs_pkg::CNT_W-1:0]     row_reg;
    logic [ksrs_pkg::CNT_W-1:0]     idx_reg;
    logic [ksrs_pkg::CNT_W-1:0]     t_reg;
    logic                           bank_reg;
    logic                           pv_reg;
    logic [ksrs_pkg::IDX_W-1:0]     pidx_reg;
    logic [ksrs_pkg::SUM_WIDTH-1:0] min_reg;
    logic [ksrs_pkg::IDX_W-1:0]     arg_reg;
    logic                           have_reg;
    logic [ksrs_pkg::CNT_W-1:0]     ptr_reg [ksrs_pkg::MAX_K];
    logic [ksrs_pkg::SUM_WIDTH-1:0] sum_reg;
    logic                           last_reg;

    logic                           in_acc;
    logic                           col_done;
    logic                           row_last;
    logic [ksrs_pkg::CNT_W-1:0]     ptr_sel;
    logic                           cand;
    logic [ksrs_pkg::SUM_WIDTH:0]   raw_sum;
    logic [ksrs_pkg::SUM_WIDTH-1:0] cand_sum;

    ksrs_pkg::sort_ctrl_t              sort_ctrl;
    logic [ksrs_pkg::IDX_W-1:0]        sort_idx;
    logic [ksrs_pkg::VALUE_WIDTH-1:0]  sort_data;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [ksrs_pkg::SUM_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [ksrs_pkg::SUM_WIDTH-1:0] ram_rdata;

    // Effective list size: zero acts as one, large values clamp to the maximum.
    always_comb
    begin
        if (list_size_reg == '0)
        begin
            k = ksrs_pkg::CNT_W'(1);
        end
        else if (ksrs_pkg::CNT_W'(list_size_reg) > ksrs_pkg::CNT_W'(ksrs_pkg::MAX_K)
                 || (ksrs_pkg::LS_WIDTH > ksrs_pkg::CNT_W
                     && list_size_reg > ksrs_pkg::LS_WIDTH'(ksrs_pkg::MAX_K)))
        begin
            k = ksrs_pkg::CNT_W'(ksrs_pkg::MAX_K);
        end
        else
        begin
            k = ksrs_pkg::CNT_W'(list_size_reg);
        end
    end

    assign k_m1     = k - ksrs_pkg::CNT_W'(1);
    assign in_acc   = in_valid && in_ready;
    assign col_done = (col_reg == k_m1);
    assign row_last = (row_reg == k_m1);

    // Candidate from the list whose best entry is arriving from memory.
    assign ptr_sel  = ptr_reg[pidx_reg];
    assign cand     = pv_reg && (ptr_sel < k);
    assign raw_sum  = {1'b0, ram_rdata}
                    + (ksrs_pkg::SUM_WIDTH + 1)'(sort_data);
    assign cand_sum = raw_sum[ksrs_pkg::SUM_WIDTH] ? ksrs_pkg::SUM_MAX
                                                   : raw_sum[ksrs_pkg::SUM_WIDTH-1:0];

    // Row sorter hookup.
    assign sort_ctrl.ins   = in_acc;
    assign sort_ctrl.count = col_reg;
    assign sort_idx = (state_reg == ksrs_pkg::S_COPY) ? idx_reg[ksrs_pkg::IDX_W-1:0]
                                                      : ptr_sel[ksrs_pkg::IDX_W-1:0];

    ksrs_row_sorter u_sorter (
        .clk      (clk),
        .ctrl     (sort_ctrl),
        .in_value (value),
        .rd_idx   (sort_idx),
        .rd_data  (sort_data)
    );

    // List memory: two banks, current best list and the list being merged.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, idx_reg[ksrs_pkg::IDX_W-1:0]};
        ram_wdata = ksrs_pkg::SUM_WIDTH'(sort_data);
        if (state_reg == ksrs_pkg::S_COPY)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ksrs_pkg::S_WRITE)
        begin
            ram_we    = 1'b1;
            ram_waddr = {~bank_reg, t_reg[ksrs_pkg::IDX_W-1:0]};
            ram_wdata = min_reg;
        end
    end

    assign ram_raddr = {bank_reg, idx_reg[ksrs_pkg::IDX_W-1:0]};

    ksrs_ram #(
        .WIDTH (ksrs_pkg::SUM_WIDTH),
        .DEPTH (2 * ksrs_pkg::MAX_K)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ksrs_pkg::S_IN:
            begin
                if (in_acc && col_done)
                begin
                    state_next = (row_reg == '0) ? ksrs_pkg::S_COPY : ksrs_pkg::S_SCAN;
                end
            end
            ksrs_pkg::S_COPY:
            begin
                if (idx_reg == k_m1)
                begin
                    state_next = row_last ? ksrs_pkg::S_OUT_RD : ksrs_pkg::S_IN;
                end
            end
            ksrs_pkg::S_SCAN:
            begin
                if (idx_reg == k && !pv_reg)
                begin
                    state_next = ksrs_pkg::S_WRITE;
                end
            end
            ksrs_pkg::S_WRITE:
            begin
                if (t_reg == k_m1)
                begin
                    state_next = row_last ? ksrs_pkg::S_OUT_RD : ksrs_pkg::S_IN;
                end
                else
                begin
                    state_next = ksrs_pkg::S_SCAN;
                end
            end
            ksrs_pkg::S_OUT_RD:
            begin
                state_next = ksrs_pkg::S_OUT_LD;
            end
            ksrs_pkg::S_OUT_LD:
            begin
                state_next = ksrs_pkg::S_OUT_WAIT;
            end
            ksrs_pkg::S_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? ksrs_pkg::S_IN : ksrs_pkg::S_OUT_RD;
                end
            end
            default:
            begin
                state_next = ksrs_pkg::S_IN;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == ksrs_pkg::S_IN);
        out_valid = (state_reg == ksrs_pkg::S_OUT_WAIT);
    end

    assign sum  = sum_reg;
    assign last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksrs_pkg::S_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Counters and merge bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= ksrs_pkg::LIST_SIZE_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            t_reg         <= '0;
            bank_reg      <= 1'b0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            arg_reg       <= '0;
            have_reg      <= 1'b0;
            last_reg      <= 1'b0;
            for (int j = 0; j < ksrs_pkg::MAX_K; j++)
            begin
                ptr_reg[j] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            list_size_reg <= cfg_wr_data;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ksrs_pkg::S_IN:
                begin
                    if (in_acc)
                    begin
                        col_reg  <= col_done ? '0 : col_reg + ksrs_pkg::CNT_W'(1);
                        idx_reg  <= '0;
                        t_reg    <= '0;
                        have_reg <= 1'b0;
                        pv_reg   <= 1'b0;
                        for (int j = 0; j < ksrs_pkg::MAX_K; j++)
                        begin
                            ptr_reg[j] <= '0;
                        end
                    end
                end
                ksrs_pkg::S_COPY:
                begin
                    if (idx_reg == k_m1)
                    begin
                        idx_reg <= '0;
                        row_reg <= row_last ? '0 : row_reg + ksrs_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ksrs_pkg::CNT_W'(1);
                    end
                end
                ksrs_pkg::S_SCAN:
                begin
                    pv_reg   <= (idx_reg < k);
                    pidx_reg <= idx_reg[ksrs_pkg::IDX_W-1:0];
                    if (idx_reg < k)
                    begin
                        idx_reg <= idx_reg + ksrs_pkg::CNT_W'(1);
                    end
                    if (cand && (!have_reg || cand_sum < min_reg))
                    begin
                        have_reg <= 1'b1;
                        arg_reg  <= pidx_reg;
                    end
                end
                ksrs_pkg::S_WRITE:
                begin
                    for (int j = 0; j < ksrs_pkg::MAX_K; j++)
                    begin
                        if (arg_reg == ksrs_pkg::IDX_W'(j))
                        begin
                            ptr_reg[j] <= ptr_reg[j] + ksrs_pkg::CNT_W'(1);
                        end
                    end
                    idx_reg  <= '0;
                    have_reg <= 1'b0;
                    pv_reg   <= 1'b0;
                    t_reg    <= t_reg + ksrs_pkg::CNT_W'(1);
                    if (t_reg == k_m1)
                    begin
                        bank_reg <= ~bank_reg;
                        row_reg  <= row_last ? '0 : row_reg + ksrs_pkg::CNT_W'(1);
                    end
                end
                ksrs_pkg::S_OUT_LD:
                begin
                    last_reg <= (idx_reg == k_m1);
                end
                ksrs_pkg::S_OUT_WAIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + ksrs_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: running minimum and output sum.
    always_ff @(posedge clk)
    begin
        if (state_reg == ksrs_pkg::S_SCAN && cand && (!have_reg || cand_sum < min_reg))
        begin
            min_reg <= cand_sum;
        end
        if (state_reg == ksrs_pkg::S_OUT_LD)
        begin
            sum_reg <= ram_rdata;
        end
    end

    `KSRS_ASSERT_SAME(a_write_has_min, state_reg == ksrs_pkg::S_WRITE, have_reg, "merge write without a candidate")
    `KSRS_ASSERT_SAME(a_out_in_range, out_valid, idx_reg < k, "output index beyond list size")
    `KSRS_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && last, state_reg == ksrs_pkg::S_IN, "no return to input after last sum")
    `KSRS_ASSERT_SAME(a_col_in_range, in_ready && !cfg_wr_en, col_reg < k, "column counter beyond list size")

endmodule
